FILE: rtl/core/gyro_bias_calibrate_and_scale_defines.svh
// Assertion macros for the gyro bias and scaling block
`ifndef GYRO_BIAS_CALIBRATE_AND_SCALE_DEFINES_SVH
`define GYRO_BIAS_CALIBRATE_AND_SCALE_DEFINES_SVH

// same-cycle implication
`define GBCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gbcs_pkg.sv
`default_nettype none

package gbcs_pkg;

  typedef enum logic {
    CMD_CAL  = 1'b0,
    CMD_CONV = 1'b1
  } cmd_t;

  localparam int RATE_K = 26;
  localparam logic [18:0] RATE_MUL = 19'(((64'd5 << RATE_K) + 64'd655) / 64'd656);

  localparam int ACC_K = 37;
  localparam logic [36:0] ACC_MUL =
    37'(((64'd1024000 << ACC_K) + 64'd1673468) / 64'd1673469);

  localparam int TMP_K = 23;
  localparam logic [18:0] TMP_MUL = 19'(((64'd1 << TMP_K) + 64'd16) / 64'd17);
  localparam logic signed [18:0] TMP_BIAS = 19'sd62101;

endpackage

`default_nettype wire

FILE: rtl/core/gyro_bias_calibrate_and_scale.sv
// Gyro bias calibration and unit scaling for a six-axis IMU sample stream.
// Input channel (in_valid/in_ready) carries a command bit and seven raw signed
// 16-bit words. A calibration transfer accumulates the gyro axes and gives no
// result; every CAL_SAMPLES calibration transfers the offsets are refreshed
// with the truncated mean and the accumulators clear. A convert transfer gives
// one result on the output channel (out_valid/out_ready): bias-corrected gyro
// rates in deg/s, acceleration in 1/1024 m/s^2, temperature in 0.01 degC.
// Path: a convert item waits in the input register; its result is then
// registered once the output register is free and no offset divide runs.
// Throughput: one transfer per cycle when not stalled. A convert item that
// follows the calibration item closing a batch waits in the input register
// while the three-step offset divide pipeline writes new offsets.
// Output stall: a held result stays in the output register; the input
// register keeps one more item; calibration items flow until a convert waits.
// Reset (rst_n low, synchronous): both channels empty, sums, sample count
// and offsets cleared to zero.
`default_nettype none

`include "gyro_bias_calibrate_and_scale_defines.svh"

module gyro_bias_calibrate_and_scale #(
  parameter int CAL_SAMPLES = 50
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic signed [15:0] in_gyro_x_raw,
  input  logic signed [15:0] in_gyro_y_raw,
  input  logic signed [15:0] in_gyro_z_raw,
  input  logic signed [15:0] in_accel_x_raw,
  input  logic signed [15:0] in_accel_y_raw,
  input  logic signed [15:0] in_accel_z_raw,
  input  logic signed [15:0] in_temp_raw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [9:0]  out_rate_x_dps,
  output logic signed [9:0]  out_rate_y_dps,
  output logic signed [9:0]  out_rate_z_dps,
  output logic signed [15:0] out_accel_x_scaled,
  output logic signed [15:0] out_accel_y_scaled,
  output logic signed [15:0] out_accel_z_scaled,
  output logic signed [14:0] out_temp_centi_c
);

  localparam int SUM_W  = 16 + $clog2(CAL_SAMPLES);
  localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
  localparam int DIV_K  = SUM_W - 1 + $clog2(CAL_SAMPLES);
  localparam int PROD_W = 2 * SUM_W;
  localparam logic [SUM_W-1:0] DIV_MUL =
    SUM_W'(((64'd1 << DIV_K) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAL_SAMPLES - 1);

  function automatic logic signed [9:0] gyro_rate(input logic signed [15:0] raw,
                                                  input logic signed [15:0] off);
    logic signed [16:0] d;
    logic [15:0]        mag;
    logic [34:0]        prod;
    logic [9:0]         q;
    d    = $signed({raw[15], raw}) - $signed({off[15], off});
    mag  = d[16] ? 16'(-d) : d[15:0];
    prod = 35'(mag) * 35'(gbcs_pkg::RATE_MUL);
    q    = {1'b0, prod[gbcs_pkg::RATE_K +: 9]};
    gyro_rate = d[16] ? $signed(-q) : $signed(q);
  endfunction

  function automatic logic signed [15:0] accel_scale(input logic signed [15:0] raw);
    logic [15:0] mag;
    logic [52:0] prod;
    logic [15:0] q;
    mag  = raw[15] ? 16'(-raw) : raw;
    prod = 53'(mag) * 53'(gbcs_pkg::ACC_MUL);
    q    = {1'b0, prod[gbcs_pkg::ACC_K +: 15]};
    accel_scale = raw[15] ? $signed(-q) : $signed(q);
  endfunction

  function automatic logic signed [14:0] temp_scale(input logic signed [15:0] raw);
    logic signed [18:0] ext;
    logic signed [18:0] n;
    logic [17:0]        mag;
    logic [36:0]        prod;
    logic [14:0]        q;
    ext  = $signed({{3{raw[15]}}, raw});
    n    = ext + (ext <<< 2) + gbcs_pkg::TMP_BIAS;
    mag  = n[18] ? 18'(-n) : n[17:0];
    prod = 37'(mag) * 37'(gbcs_pkg::TMP_MUL);
    q    = {1'b0, prod[gbcs_pkg::TMP_K +: 14]};
    temp_scale = n[18] ? $signed(-q) : $signed(q);
  endfunction

  logic                     s1_vld_r, s1_vld_nxt;
  gbcs_pkg::cmd_t           s1_cmd_r;
  logic signed [15:0]       s1_gyro_r  [3];
  logic signed [15:0]       s1_accel_r [3];
  logic signed [15:0]       s1_temp_r;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [9:0]        out_rate_r  [3];
  logic signed [15:0]       out_accel_r [3];
  logic signed [14:0]       out_temp_r;

  logic signed [SUM_W-1:0]  sum_r [3];
  logic signed [SUM_W-1:0]  sum_nxt [3];
  logic signed [SUM_W-1:0]  sum_add [3];
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;

  logic                     div_a_vld_r, div_b_vld_r;
  logic signed [SUM_W-1:0]  div_sum_r [3];
  logic [SUM_W-1:0]         div_mag   [3];
  logic [PROD_W-1:0]        div_prod  [3];
  logic [15:0]              div_q_r   [3];
  logic                     div_neg_r [3];
  logic signed [15:0]       offset_r   [3];
  logic signed [15:0]       offset_nxt [3];

  logic in_xfer, out_free, div_busy, s1_go, cal_go, conv_go, cal_last;

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign div_busy = div_a_vld_r || div_b_vld_r;
  assign s1_go    = s1_vld_r &&
                    ((s1_cmd_r == gbcs_pkg::CMD_CAL) || (!div_busy && out_free));
  assign cal_go   = s1_go && (s1_cmd_r == gbcs_pkg::CMD_CAL);
  assign conv_go  = s1_go && (s1_cmd_r == gbcs_pkg::CMD_CONV);
  assign cal_last = (cnt_r == CNT_LAST);
  assign in_ready = !s1_vld_r || s1_go;

  assign s1_vld_nxt    = in_xfer || (s1_vld_r && !s1_go);
  assign out_valid_nxt = conv_go || (out_valid_r && !out_ready);

  always_comb begin
    cnt_nxt = cnt_r;
    if (cal_go) begin
      cnt_nxt = cal_last ? '0 : cnt_r + CNT_W'(1);
    end
    for (int i = 0; i < 3; i++) begin
      sum_add[i]  = sum_r[i] + SUM_W'(s1_gyro_r[i]);
      sum_nxt[i]  = sum_r[i];
      if (cal_go) begin
        sum_nxt[i] = cal_last ? '0 : sum_add[i];
      end
      div_mag[i]  = div_sum_r[i][SUM_W-1] ? SUM_W'(-div_sum_r[i]) : div_sum_r[i];
      div_prod[i] = PROD_W'(div_mag[i]) * PROD_W'(DIV_MUL);
      offset_nxt[i] = offset_r[i];
      if (div_b_vld_r) begin
        offset_nxt[i] = div_neg_r[i] ? $signed(-div_q_r[i]) : $signed(div_q_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      div_a_vld_r <= 1'b0;
      div_b_vld_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i]    <= '0;
        offset_r[i] <= '0;
      end
    end else begin
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      div_a_vld_r <= cal_go && cal_last;
      div_b_vld_r <= div_a_vld_r;
      for (int i = 0; i < 3; i++) begin
        sum_r[i]    <= sum_nxt[i];
        offset_r[i] <= offset_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r      <= gbcs_pkg::cmd_t'(in_command);
      s1_gyro_r[0]  <= in_gyro_x_raw;
      s1_gyro_r[1]  <= in_gyro_y_raw;
      s1_gyro_r[2]  <= in_gyro_z_raw;
      s1_accel_r[0] <= in_accel_x_raw;
      s1_accel_r[1] <= in_accel_y_raw;
      s1_accel_r[2] <= in_accel_z_raw;
      s1_temp_r     <= in_temp_raw;
    end
    if (conv_go) begin
      for (int i = 0; i < 3; i++) begin
        out_rate_r[i]  <= gyro_rate(s1_gyro_r[i], offset_r[i]);
        out_accel_r[i] <= accel_scale(s1_accel_r[i]);
      end
      out_temp_r <= temp_scale(s1_temp_r);
    end
    for (int i = 0; i < 3; i++) begin
      if (cal_go && cal_last) begin
        div_sum_r[i] <= sum_add[i];
      end
      if (div_a_vld_r) begin
        div_q_r[i]   <= div_prod[i][DIV_K +: 16];
        div_neg_r[i] <= div_sum_r[i][SUM_W-1];
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_rate_x_dps     = out_rate_r[0];
  assign out_rate_y_dps     = out_rate_r[1];
  assign out_rate_z_dps     = out_rate_r[2];
  assign out_accel_x_scaled = out_accel_r[0];
  assign out_accel_y_scaled = out_accel_r[1];
  assign out_accel_z_scaled = out_accel_r[2];
  assign out_temp_centi_c   = out_temp_r;

  `GBCS_ASSERT_IMP(a_conv_after_offsets, conv_go, !div_busy, "convert overtook offsets")
  `GBCS_ASSERT_NXT(a_batch_closes, cal_go && cal_last, div_a_vld_r && cnt_r == '0, "batch open")
  `GBCS_ASSERT_NXT(a_cal_no_result, cal_go && !out_valid_r, !out_valid_r, "cal gave result")
  `GBCS_ASSERT_IMP(a_rate, out_valid_r, out_rate_r[0] < 500 && out_rate_r[0] > -500, "bad rate")

endmodule

`default_nettype wire

FILE: verif/tb.sv
module tb;
  import gbcs_pkg::*;

  localparam int CAL_SAMPLES  = 50;
  localparam int ITEM_TARGET  = 2000;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 20;

  typedef struct packed {
    logic               barrier;
    cmd_t               cmd;
    logic signed [15:0] gx, gy, gz;
    logic signed [15:0] ax, ay, az;
    logic signed [15:0] tr;
  } sample_t;

  typedef struct packed {
    logic signed [9:0]  rx, ry, rz;
    logic signed [15:0] ax, ay, az;
    logic signed [14:0] tc;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_command = CMD_CAL;
  logic signed [15:0] in_gyro_x_raw = '0;
  logic signed [15:0] in_gyro_y_raw = '0;
  logic signed [15:0] in_gyro_z_raw = '0;
  logic signed [15:0] in_accel_x_raw = '0;
  logic signed [15:0] in_accel_y_raw = '0;
  logic signed [15:0] in_accel_z_raw = '0;
  logic signed [15:0] in_temp_raw = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [9:0]  out_rate_x_dps;
  logic signed [9:0]  out_rate_y_dps;
  logic signed [9:0]  out_rate_z_dps;
  logic signed [15:0] out_accel_x_scaled;
  logic signed [15:0] out_accel_y_scaled;
  logic signed [15:0] out_accel_z_scaled;
  logic signed [14:0] out_temp_centi_c;

  sample_t  pending [$];
  reading_t readings_due [$];
  sample_t  on_bus;

  int cal_sum [3];
  int gyro_offset [3];
  int cal_taken = 0;

  int  errors = 0;
  int  sent = 0;
  int  converts_sent = 0;
  int  checked = 0;
  int  batches = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  calm = 1'b0;
  bit  timed_out = 1'b0;

  gyro_bias_calibrate_and_scale #(.CAL_SAMPLES(CAL_SAMPLES)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_gyro_x_raw      (in_gyro_x_raw),
    .in_gyro_y_raw      (in_gyro_y_raw),
    .in_gyro_z_raw      (in_gyro_z_raw),
    .in_accel_x_raw     (in_accel_x_raw),
    .in_accel_y_raw     (in_accel_y_raw),
    .in_accel_z_raw     (in_accel_z_raw),
    .in_temp_raw        (in_temp_raw),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_rate_x_dps     (out_rate_x_dps),
    .out_rate_y_dps     (out_rate_y_dps),
    .out_rate_z_dps     (out_rate_z_dps),
    .out_accel_x_scaled (out_accel_x_scaled),
    .out_accel_y_scaled (out_accel_y_scaled),
    .out_accel_z_scaled (out_accel_z_scaled),
    .out_temp_centi_c   (out_temp_centi_c)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (errors < 50) begin
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    end
    errors++;
  endtask

  task automatic apply_sample(input sample_t s);
    int       gyro [3];
    longint   accel [3];
    int       temp_raw;
    reading_t r;
    gyro[0]  = $signed(s.gx);
    gyro[1]  = $signed(s.gy);
    gyro[2]  = $signed(s.gz);
    accel[0] = $signed(s.ax);
    accel[1] = $signed(s.ay);
    accel[2] = $signed(s.az);
    temp_raw = $signed(s.tr);
    if (s.cmd == CMD_CAL) begin
      for (int i = 0; i < 3; i++) cal_sum[i] += gyro[i];
      cal_taken++;
      if (cal_taken >= CAL_SAMPLES) begin
        for (int i = 0; i < 3; i++) begin
          gyro_offset[i] = cal_sum[i] / CAL_SAMPLES;
          cal_sum[i] = 0;
        end
        cal_taken = 0;
        batches++;
      end
    end else begin
      r.rx = 10'((gyro[0] - gyro_offset[0]) * 5 / 656);
      r.ry = 10'((gyro[1] - gyro_offset[1]) * 5 / 656);
      r.rz = 10'((gyro[2] - gyro_offset[2]) * 5 / 656);
      r.ax = 16'(accel[0] * 1024000 / 1673469);
      r.ay = 16'(accel[1] * 1024000 / 1673469);
      r.az = 16'(accel[2] * 1024000 / 1673469);
      r.tc = 15'((62101 + 5 * temp_raw) / 17);
      readings_due.push_back(r);
      converts_sent++;
    end
  endtask

  task automatic check_reading();
    reading_t want;
    if (readings_due.size() == 0) begin
      report_mismatch("result with nothing expected", out_rate_x_dps, 0);
      return;
    end
    want = readings_due.pop_front();
    if (out_rate_x_dps !== want.rx) report_mismatch("rate_x_dps", out_rate_x_dps, want.rx);
    if (out_rate_y_dps !== want.ry) report_mismatch("rate_y_dps", out_rate_y_dps, want.ry);
    if (out_rate_z_dps !== want.rz) report_mismatch("rate_z_dps", out_rate_z_dps, want.rz);
    if (out_accel_x_scaled !== want.ax) begin
      report_mismatch("accel_x_scaled", out_accel_x_scaled, want.ax);
    end
    if (out_accel_y_scaled !== want.ay) begin
      report_mismatch("accel_y_scaled", out_accel_y_scaled, want.ay);
    end
    if (out_accel_z_scaled !== want.az) begin
      report_mismatch("accel_z_scaled", out_accel_z_scaled, want.az);
    end
    if (out_temp_centi_c !== want.tc) report_mismatch("temp_centi_c", out_temp_centi_c, want.tc);
  endtask

  function automatic int pick_raw();
    case ($urandom_range(9))
      0: pick_raw = ($urandom_range(1) == 0) ? -32768 : 32767;
      1: pick_raw = $urandom_range(2) - 1;
      default: pick_raw = $signed(16'($urandom));
    endcase
  endfunction

  function automatic int gyro_draw(input int style, input int base);
    int v;
    case (style)
      0: v = pick_raw();
      1: v = base;
      default: begin
        v = base + $urandom_range(64) - 32;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
    endcase
    return v;
  endfunction

  task automatic queue_sample(input cmd_t c, input int gx, input int gy, input int gz,
                              input int ax, input int ay, input int az, input int tr);
    sample_t s;
    s.barrier = 1'b0;
    s.cmd = c;
    s.gx = 16'(gx);
    s.gy = 16'(gy);
    s.gz = 16'(gz);
    s.ax = 16'(ax);
    s.ay = 16'(ay);
    s.az = 16'(az);
    s.tr = 16'(tr);
    pending.push_back(s);
  endtask

  task automatic queue_convert();
    queue_sample(CMD_CONV, pick_raw(), pick_raw(), pick_raw(),
                 pick_raw(), pick_raw(), pick_raw(), pick_raw());
  endtask

  task automatic queue_drain_pause();
    sample_t s;
    s = '0;
    s.barrier = 1'b1;
    pending.push_back(s);
  endtask

  task automatic build_stimulus();
    int style;
    int base [3];
    int seg;
    int n;
    queue_sample(CMD_CONV, 0, 0, 0, 0, 0, 0, 0);
    queue_sample(CMD_CONV, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    queue_sample(CMD_CONV, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    queue_sample(CMD_CONV, 655, 656, -656, 1, -1, 2, -12420);
    queue_sample(CMD_CONV, -1, 1, -655, -2, 1674, -1674, -12421);
    queue_sample(CMD_CONV, 131, -132, 32766, 1673, -1673, 32767, -12424);
    for (int k = 0; k < 4; k++) begin
      queue_sample(CMD_CAL, 32767, -32768, 32767, pick_raw(), pick_raw(), pick_raw(),
                   pick_raw());
    end
    queue_sample(CMD_CONV, 32767, -32768, 0, 0, 0, 0, 32767);
    queue_sample(CMD_CAL, -32768, 32767, -1, 0, 0, 0, 0);
    queue_sample(CMD_CONV, -32768, 32767, 1, -1, 1, -1, -1);
    queue_drain_pause();

    seg = 0;
    while (pending.size() < ITEM_TARGET) begin
      if (seg == 12 || seg == 30) queue_drain_pause();
      if ($urandom_range(9) < 7) begin
        style = $urandom_range(2);
        for (int i = 0; i < 3; i++) begin
          base[i] = (style == 1) ? (($urandom_range(1) == 0) ? -32768 : 32767) : pick_raw();
        end
        for (int k = 0; k < CAL_SAMPLES; k++) begin
          queue_sample(CMD_CAL, gyro_draw(style, base[0]), gyro_draw(style, base[1]),
                       gyro_draw(style, base[2]), pick_raw(), pick_raw(), pick_raw(),
                       pick_raw());
          if ($urandom_range(11) == 0) queue_convert();
        end
        n = $urandom_range(30, 3);
        for (int k = 0; k < n; k++) queue_convert();
      end else begin
        n = $urandom_range(40, 5);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(1) == 0) begin
            queue_convert();
          end else begin
            queue_sample(CMD_CAL, pick_raw(), pick_raw(), pick_raw(), pick_raw(), pick_raw(),
                         pick_raw(), pick_raw());
          end
        end
      end
      seg++;
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        apply_sample(on_bus);
        sent <= sent + 1;
      end
      calm <= (sent >= 1000) && (sent < 1400);
      if (pending.size() > 0 && pending[0].barrier) begin
        if (converts_sent == checked) void'(pending.pop_front());
        in_valid <= 1'b0;
      end else if (pending.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
        on_bus = pending.pop_front();
        in_command     <= on_bus.cmd;
        in_gyro_x_raw  <= on_bus.gx;
        in_gyro_y_raw  <= on_bus.gy;
        in_gyro_z_raw  <= on_bus.gz;
        in_accel_x_raw <= on_bus.ax;
        in_accel_y_raw <= on_bus.ay;
        in_accel_z_raw <= on_bus.az;
        in_temp_raw    <= on_bus.tr;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_reading();
        checked <= checked + 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && sent >= 700) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    build_stimulus();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (!timed_out && (pending.size() > 0 || in_valid || readings_due.size() > 0)) begin
      @(negedge clk);
      timed_out = idle_cycles >= STALL_LIMIT;
    end
    if (!timed_out) begin
      repeat (TAIL_CYCLES) @(posedge clk);
      if (readings_due.size() != 0) report_mismatch("results never seen", readings_due.size(), 0);
    end
    $display("Transferred %0d samples, checked %0d conversions, closed %0d calibration batches",
             sent, checked, batches);
    $display("Run included extreme raw words, mid-batch conversions, a %0d-cycle output hold",
             HOLD_CYCLES);
    if (timed_out || errors != 0) begin
      $display("Test completed with failures");
    end else begin
      $display("Test completed successfully");
    end
    $finish;
  end

endmodule
